// ===== hw/rtl/krio_pkg.sv =====
// package: shared constants, codes and helper functions of the keypad / clock / i/o block
`timescale 1ns / 1ps

package krio_pkg;

    // key queue geometry
    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // clock field store geometry
    localparam int TIME_FIELDS = 6;
    localparam int TIME_AW     = $clog2(TIME_FIELDS);
    localparam logic [3:0] TIME_SEL_MAX = 4'd11;

    // commands
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_KEY   = 2'd2,
        CMD_FRAME = 2'd3
    } cmd_t;

    // crtc access codes
    localparam logic [1:0] CRTC_NONE  = 2'd0;
    localparam logic [1:0] CRTC_INDEX = 2'd1;
    localparam logic [1:0] CRTC_DATA  = 2'd2;

    // decoded addresses
    localparam logic [15:0] ADDR_STATUS     = 16'h6001;
    localparam logic [15:0] ADDR_CRTC_DATA  = 16'h6002;
    localparam logic [15:0] ADDR_CRTC_INDEX = 16'h6003;
    localparam logic [15:0] ADDR_KEY        = 16'h6004;
    localparam logic [15:0] ADDR_CLOCK      = 16'h6500;
    localparam logic [3:0]  IO_AREA_NIBBLE  = 4'h6;
    localparam logic [7:0]  PORT_PAGE       = 8'h60;
    localparam logic [7:0]  CLOCK_PAGE      = 8'h63;

    // digit strobe nibbles
    localparam logic [3:0] STROBE_PREV = 4'h3;
    localparam logic [3:0] STROBE_NEW  = 4'h1;

    // status and key read masks
    localparam logic [7:0] STATUS_FIXED = 8'h7e;
    localparam logic [7:0] STATUS_NDISP = 8'h80;
    localparam logic [7:0] KEY_MASK     = 8'hfc;
    localparam logic [7:0] IDLE_BYTE    = 8'hff;
    localparam logic [7:0] KEY_RESET    = 8'hff;

    // host key code to {mapped, matrix code}
    function automatic logic [6:0] key_rom(input logic [7:0] code);
        logic [6:0] e;
        e = 7'h00;
        case (code)
            8'h0d: e = {1'b1, 6'h2c};
            8'h20: e = {1'b1, 6'h34};
            8'h21: e = {1'b1, 6'h06};
            8'h22: e = {1'b1, 6'h0e};
            8'h23: e = {1'b1, 6'h27};
            8'h24: e = {1'b1, 6'h07};
            8'h25: e = {1'b1, 6'h0c};
            8'h26: e = {1'b1, 6'h05};
            8'h27: e = {1'b1, 6'h0f};
            8'h28: e = {1'b1, 6'h0d};
            8'h30: e = {1'b1, 6'h04};
            8'h32: e = {1'b1, 6'h00};
            8'h33: e = {1'b1, 6'h08};
            8'h34: e = {1'b1, 6'h01};
            8'h35: e = {1'b1, 6'h09};
            8'h36: e = {1'b1, 6'h02};
            8'h37: e = {1'b1, 6'h0a};
            8'h38: e = {1'b1, 6'h03};
            8'h39: e = {1'b1, 6'h0b};
            8'h41: e = {1'b1, 6'h20};
            8'h42: e = {1'b1, 6'h3a};
            8'h43: e = {1'b1, 6'h39};
            8'h44: e = {1'b1, 6'h21};
            8'h45: e = {1'b1, 6'h11};
            8'h46: e = {1'b1, 6'h29};
            8'h47: e = {1'b1, 6'h22};
            8'h48: e = {1'b1, 6'h2a};
            8'h49: e = {1'b1, 6'h1b};
            8'h4a: e = {1'b1, 6'h23};
            8'h4b: e = {1'b1, 6'h2b};
            8'h4c: e = {1'b1, 6'h24};
            8'h4d: e = {1'b1, 6'h3b};
            8'h4e: e = {1'b1, 6'h32};
            8'h4f: e = {1'b1, 6'h14};
            8'h50: e = {1'b1, 6'h1c};
            8'h51: e = {1'b1, 6'h10};
            8'h52: e = {1'b1, 6'h19};
            8'h53: e = {1'b1, 6'h28};
            8'h54: e = {1'b1, 6'h12};
            8'h55: e = {1'b1, 6'h13};
            8'h56: e = {1'b1, 6'h31};
            8'h57: e = {1'b1, 6'h18};
            8'h58: e = {1'b1, 6'h30};
            8'h59: e = {1'b1, 6'h1a};
            8'h5a: e = {1'b1, 6'h38};
            8'h60: e = {1'b1, 6'h3f};
            8'h61: e = {1'b1, 6'h35};
            8'h62: e = {1'b1, 6'h3d};
            8'h63: e = {1'b1, 6'h3e};
            8'h64: e = {1'b1, 6'h25};
            8'h65: e = {1'b1, 6'h2d};
            8'h66: e = {1'b1, 6'h26};
            8'h67: e = {1'b1, 6'h15};
            8'h68: e = {1'b1, 6'h1d};
            8'h69: e = {1'b1, 6'h16};
            8'h6a: e = {1'b1, 6'h2e};
            8'h6b: e = {1'b1, 6'h37};
            8'h6c: e = {1'b1, 6'h2f};
            8'h6d: e = {1'b1, 6'h36};
            8'h6e: e = {1'b1, 6'h3c};
            8'h6f: e = {1'b1, 6'h1e};
            8'h70: e = {1'b1, 6'h35};
            8'h71: e = {1'b1, 6'h3d};
            8'h72: e = {1'b1, 6'h3e};
            8'h73: e = {1'b1, 6'h25};
            8'h74: e = {1'b1, 6'h2d};
            8'h75: e = {1'b1, 6'h26};
            8'h76: e = {1'b1, 6'h15};
            8'h77: e = {1'b1, 6'h1d};
            8'h78: e = {1'b1, 6'h16};
            8'h79: e = {1'b1, 6'h3f};
            8'ha3: e = {1'b1, 6'h2f};
            8'hba: e = {1'b1, 6'h1f};
            8'hbb: e = {1'b1, 6'h17};
            8'hbc: e = {1'b1, 6'h33};
            8'hbe: e = {1'b1, 6'h3c};
            default: e = 7'h00;
        endcase
        return e;
    endfunction

    // value mod 100, by two compare-subtract steps
    function automatic logic [6:0] mod100(input logic [7:0] v);
        logic [7:0] r;
        if (v >= 8'd200)
            r = v - 8'd200;
        else if (v >= 8'd100)
            r = v - 8'd100;
        else
            r = v;
        return r[6:0];
    endfunction

    // tens digit: (v mod 100) / 10 via reciprocal multiply, exact below 1029
    function automatic logic [3:0] tens_digit(input logic [7:0] v);
        logic [6:0]  r;
        logic [14:0] p;
        r = mod100(v);
        p = 15'(r) * 15'd205;
        return p[14:11];
    endfunction

    // units digit: v mod 10
    function automatic logic [3:0] units_digit(input logic [7:0] v);
        logic [6:0] r;
        logic [3:0] t;
        logic [6:0] s;
        r = mod100(v);
        t = tens_digit(v);
        s = r - 7'(t) * 7'd10;
        return s[3:0];
    endfunction

endpackage

// ===== hw/rtl/krio_if.sv =====
// interfaces: input word channel and result word channel
`timescale 1ns / 1ps

interface krio_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  key_code;
    logic        shift_held;
    logic        display_level;

    modport source (output valid, cmd, address, write_data, key_code, shift_held,
                    display_level, input ready);
    modport sink (input valid, cmd, address, write_data, key_code, shift_held,
                  display_level, output ready);
endinterface

interface krio_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       irq;
    logic [1:0] crtc_access;
    logic       unknown_access;
    logic       key_lost;

    modport source (output valid, read_data, irq, crtc_access, unknown_access, key_lost,
                    input ready);
    modport sink (input valid, read_data, irq, crtc_access, unknown_access, key_lost,
                  output ready);
endinterface

// ===== hw/rtl/krio_ram.sv =====
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps

module krio_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/keypad_rtc_io_port_block.sv =====
// top level: keypad queue, clock digits and i/o port decode of the emulated machine
`timescale 1ns / 1ps

// Each input word is one bus write, bus read, key press or frame tick, and
// yields exactly one result word. In the accept cycle the key queue memory
// is read at the queue head and the clock field memory at the selected
// field; in the update state the registered read data is combined, the
// result is loaded into the output register and any queue push or digit
// update is written back. The block takes no new word until the current one
// has passed its update; a new word is taken while the previous result still
// waits in the output register, and the update cycle holds only while that
// register is occupied and not taken. Key presses are mapped by a constant
// rom, and a mapped press is dropped with key_lost when the queue holds
// QUEUE_DEPTH entries. Clock fields read as zero until a digit write has set
// them (per field valid bits), so no clearing pass is needed after reset.
module keypad_rtc_io_port_block (
    input  logic          clk,
    input  logic          rst_n,
    krio_item_if.sink     item,
    krio_result_if.source result
);

    import krio_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    // control state
    state_t                state_reg, state_next;
    logic [QUEUE_AW-1:0]   head_reg, head_next;
    logic [QUEUE_CW-1:0]   count_reg, count_next;
    logic [7:0]            key_reg, key_next;
    logic                  disp_reg, disp_next;
    logic [15:0]           opt_addr_reg, opt_addr_next;
    logic [7:0]            opt_data_reg, opt_data_next;
    logic [TIME_FIELDS-1:0] tvalid_reg, tvalid_next;

    // registered outputs
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            rd_reg, rd_next;
    logic                  irq_reg, irq_next;
    logic [1:0]            crtc_reg, crtc_next;
    logic                  unk_reg, unk_next;
    logic                  lost_reg, lost_next;

    // held input word
    logic [1:0]            cmd_reg;
    logic [15:0]           addr_reg;
    logic [7:0]            wdata_reg;
    logic [7:0]            code_reg;
    logic                  shift_reg;
    logic                  level_reg;

    logic accept;
    logic exec_go;

    // queue memory ports
    logic                q_wr_en;
    logic [QUEUE_AW-1:0] q_wr_addr;
    logic [7:0]          q_wr_data;
    logic [7:0]          q_rd_data;

    // clock field memory ports
    logic [3:0]          acc_sel;
    logic                t_rd_en;
    logic                t_wr_en;
    logic [TIME_AW-1:0]  t_addr;
    logic [7:0]          t_wr_data;
    logic [7:0]          t_rd_data;

    // update-cycle helpers
    cmd_t                cmd;
    logic [3:0]          exec_sel;
    logic                sel_ok;
    logic [TIME_AW-1:0]  exec_idx;
    logic [7:0]          old_v;
    logic [3:0]          new_d;
    logic [6:0]          key_map;
    logic [QUEUE_CW:0]   slot_sum;
    logic [QUEUE_CW:0]   slot_wrap;
    logic                io_area;

    assign item.ready = (state_reg == S_IDLE);
    assign accept     = item.valid && item.ready;
    assign exec_go    = (state_reg == S_EXEC) && (!out_valid_reg || result.ready);

    // clock field select: write address for bus writes, latched option address otherwise
    assign acc_sel = (cmd_t'(item.cmd) == CMD_WRITE) ? item.address[3:0] : opt_addr_reg[3:0];
    assign t_rd_en = accept && (acc_sel <= TIME_SEL_MAX);

    assign cmd      = cmd_t'(cmd_reg);
    assign exec_sel = (cmd == CMD_WRITE) ? addr_reg[3:0] : opt_addr_reg[3:0];
    assign sel_ok   = (exec_sel <= TIME_SEL_MAX);
    assign exec_idx = exec_sel[3:1];
    assign old_v    = (sel_ok && tvalid_reg[exec_idx]) ? t_rd_data : 8'h00;
    assign new_d    = wdata_reg[3:0];

    // single address port: read address in the accept cycle, write address in the update cycle
    assign t_addr = (state_reg == S_EXEC) ? exec_idx : acc_sel[3:1];

    assign key_map   = key_rom(code_reg);
    assign slot_sum  = (QUEUE_CW + 1)'(head_reg) + (QUEUE_CW + 1)'(count_reg);
    assign slot_wrap = (slot_sum >= (QUEUE_CW + 1)'(QUEUE_DEPTH))
                       ? slot_sum - (QUEUE_CW + 1)'(QUEUE_DEPTH) : slot_sum;
    assign io_area   = (addr_reg[15:12] == IO_AREA_NIBBLE) && (addr_reg[15:8] != PORT_PAGE);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        key_next       = key_reg;
        disp_next      = disp_reg;
        opt_addr_next  = opt_addr_reg;
        opt_data_next  = opt_data_reg;
        tvalid_next    = tvalid_reg;
        out_valid_next = out_valid_reg;
        rd_next        = rd_reg;
        irq_next       = irq_reg;
        crtc_next      = crtc_reg;
        unk_next       = unk_reg;
        lost_next      = lost_reg;
        q_wr_en        = 1'b0;
        q_wr_addr      = slot_wrap[QUEUE_AW-1:0];
        q_wr_data      = {key_map[5:0], 1'b0, ~shift_reg};
        t_wr_en        = 1'b0;
        t_wr_data      = 8'h00;

        // result word taken
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    disp_next      = level_reg;
                    rd_next        = IDLE_BYTE;
                    irq_next       = 1'b0;
                    crtc_next      = CRTC_NONE;
                    unk_next       = 1'b0;
                    lost_next      = 1'b0;

                    unique case (cmd)
                        CMD_WRITE:
                        begin
                            if (addr_reg == ADDR_CRTC_DATA)
                            begin
                                crtc_next = CRTC_DATA;
                            end
                            else if (addr_reg == ADDR_CRTC_INDEX)
                            begin
                                crtc_next = CRTC_INDEX;
                            end
                            else if (io_area)
                            begin
                                if (addr_reg[15:8] == CLOCK_PAGE)
                                begin
                                    // digit strobe edge
                                    if (opt_data_reg[7:4] == STROBE_PREV
                                        && wdata_reg[7:4] == STROBE_NEW && sel_ok)
                                    begin
                                        t_wr_en = 1'b1;
                                        tvalid_next[exec_idx] = 1'b1;
                                        if (exec_sel[0])
                                        begin
                                            t_wr_data = 8'(units_digit(old_v))
                                                        + 8'(new_d) * 8'd10;
                                        end
                                        else
                                        begin
                                            t_wr_data = 8'(tens_digit(old_v)) * 8'd10
                                                        + 8'(new_d);
                                        end
                                    end
                                end
                                else
                                begin
                                    unk_next = 1'b1;
                                end
                                opt_addr_next = addr_reg;
                                opt_data_next = wdata_reg;
                            end
                            else
                            begin
                                unk_next = 1'b1;
                            end
                        end
                        CMD_READ:
                        begin
                            if (addr_reg == ADDR_STATUS)
                            begin
                                rd_next = (level_reg ? 8'h00 : STATUS_NDISP) | STATUS_FIXED
                                          | {7'h00, key_reg[0]};
                            end
                            else if (addr_reg == ADDR_CRTC_DATA)
                            begin
                                crtc_next = CRTC_DATA;
                            end
                            else if (addr_reg == ADDR_CRTC_INDEX)
                            begin
                                crtc_next = CRTC_INDEX;
                            end
                            else if (addr_reg == ADDR_KEY)
                            begin
                                rd_next = key_reg & KEY_MASK;
                            end
                            else if (addr_reg == ADDR_CLOCK
                                     && opt_addr_reg[15:8] == CLOCK_PAGE)
                            begin
                                if (!sel_ok)
                                begin
                                    rd_next = 8'h00;
                                end
                                else if (exec_sel[0])
                                begin
                                    rd_next = 8'(tens_digit(old_v));
                                end
                                else
                                begin
                                    rd_next = 8'(units_digit(old_v));
                                end
                            end
                            else
                            begin
                                unk_next = 1'b1;
                            end
                        end
                        CMD_KEY:
                        begin
                            if (key_map[6])
                            begin
                                if (count_reg == QUEUE_CW'(QUEUE_DEPTH))
                                begin
                                    lost_next = 1'b1;
                                end
                                else
                                begin
                                    q_wr_en    = 1'b1;
                                    count_next = count_reg + 1'b1;
                                end
                            end
                        end
                        CMD_FRAME:
                        begin
                            if (count_reg != '0)
                            begin
                                key_next   = q_rd_data;
                                head_next  = (head_reg == QUEUE_AW'(QUEUE_DEPTH - 1))
                                             ? '0 : head_reg + 1'b1;
                                count_next = count_reg - 1'b1;
                                irq_next   = 1'b1;
                            end
                        end
                        default:
                        begin
                            unk_next = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            key_reg       <= KEY_RESET;
            disp_reg      <= 1'b0;
            opt_addr_reg  <= '0;
            opt_data_reg  <= '0;
            tvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
            rd_reg        <= IDLE_BYTE;
            irq_reg       <= 1'b0;
            crtc_reg      <= CRTC_NONE;
            unk_reg       <= 1'b0;
            lost_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            key_reg       <= key_next;
            disp_reg      <= disp_next;
            opt_addr_reg  <= opt_addr_next;
            opt_data_reg  <= opt_data_next;
            tvalid_reg    <= tvalid_next;
            out_valid_reg <= out_valid_next;
            rd_reg        <= rd_next;
            irq_reg       <= irq_next;
            crtc_reg      <= crtc_next;
            unk_reg       <= unk_next;
            lost_reg      <= lost_next;
        end
    end

    // input word capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= item.cmd;
            addr_reg  <= item.address;
            wdata_reg <= item.write_data;
            code_reg  <= item.key_code;
            shift_reg <= item.shift_held;
            level_reg <= item.display_level;
        end
    end

    // key queue: read at head on accept, push in the update cycle
    krio_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .clk     (clk),
        .wr_en   (q_wr_en),
        .wr_addr (q_wr_addr),
        .wr_data (q_wr_data),
        .rd_en   (accept),
        .rd_addr (head_reg),
        .rd_data (q_rd_data)
    );

    // clock fields: read on accept, digit write-back in the update cycle
    krio_ram #(
        .WIDTH (8),
        .DEPTH (TIME_FIELDS)
    ) u_time_ram (
        .clk     (clk),
        .wr_en   (t_wr_en),
        .wr_addr (t_addr),
        .wr_data (t_wr_data),
        .rd_en   (t_rd_en),
        .rd_addr (t_addr),
        .rd_data (t_rd_data)
    );

    assign result.valid          = out_valid_reg;
    assign result.read_data      = rd_reg;
    assign result.irq            = irq_reg;
    assign result.crtc_access    = crtc_reg;
    assign result.unknown_access = unk_reg;
    assign result.key_lost       = lost_reg;

endmodule

// ===== hw/rtl/krio_checker.sv =====
// checker: port-level assertions on the result channel, bound to the top level
`timescale 1ns / 1ps

module krio_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] read_data,
    input logic       irq,
    input logic [1:0] crtc_access,
    input logic       unknown_access,
    input logic       key_lost
);

    import krio_pkg::*;

    // a stalled result word stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result word dropped while stalled");

    // a frame tick and a key press never share one word
    a_irq_lost: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(irq && key_lost))
        else $error("irq and key_lost together");

    // crtc port access returns no data and is decoded
    a_crtc: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && crtc_access != CRTC_NONE |->
            read_data == IDLE_BYTE && !unknown_access && !irq && !key_lost)
        else $error("crtc access with data or flags");

    // an undecoded access reads idle byte
    a_unknown: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && unknown_access |-> read_data == IDLE_BYTE && crtc_access == CRTC_NONE)
        else $error("undecoded access with data");

endmodule

bind keypad_rtc_io_port_block krio_checker u_krio_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .read_data      (result.read_data),
    .irq            (result.irq),
    .crtc_access    (result.crtc_access),
    .unknown_access (result.unknown_access),
    .key_lost       (result.key_lost)
);

// ===== dv/tb_keypad_rtc_io_port_block.sv =====
// testbench: keypad queue, clock digit and port decode checks against a predictor of the block
`timescale 1ns / 1ps

import krio_pkg::*;

// one input word as it crosses the item channel
typedef struct packed {
    cmd_t        cmd;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  key_code;
    logic        shift_held;
    logic        display_level;
} bus_word_t;

// one result word as it crosses the result channel
typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
    logic [1:0] crtc_access;
    logic       unknown_access;
    logic       key_lost;
} port_result_t;

class port_result_tracker;
    logic [7:0]  queue_mirror [QUEUE_DEPTH];
    int          fifo_head;
    int          fifo_count;
    logic [7:0]  key_reg;
    logic        disp_flag;
    logic [15:0] opt_addr;
    logic [7:0]  opt_data;
    logic [7:0]  clock_field [TIME_FIELDS];
    logic [6:0]  matrix_map [256];
    port_result_t awaited_results [$];
    int          mismatches;

    function new();
        foreach (matrix_map[i])
            matrix_map[i] = 7'h00;
        map_key(8'h0d, 6'h2c); map_key(8'h20, 6'h34); map_key(8'h21, 6'h06);
        map_key(8'h22, 6'h0e); map_key(8'h23, 6'h27); map_key(8'h24, 6'h07);
        map_key(8'h25, 6'h0c); map_key(8'h26, 6'h05); map_key(8'h27, 6'h0f);
        map_key(8'h28, 6'h0d); map_key(8'h30, 6'h04); map_key(8'h32, 6'h00);
        map_key(8'h33, 6'h08); map_key(8'h34, 6'h01); map_key(8'h35, 6'h09);
        map_key(8'h36, 6'h02); map_key(8'h37, 6'h0a); map_key(8'h38, 6'h03);
        map_key(8'h39, 6'h0b); map_key(8'h41, 6'h20); map_key(8'h42, 6'h3a);
        map_key(8'h43, 6'h39); map_key(8'h44, 6'h21); map_key(8'h45, 6'h11);
        map_key(8'h46, 6'h29); map_key(8'h47, 6'h22); map_key(8'h48, 6'h2a);
        map_key(8'h49, 6'h1b); map_key(8'h4a, 6'h23); map_key(8'h4b, 6'h2b);
        map_key(8'h4c, 6'h24); map_key(8'h4d, 6'h3b); map_key(8'h4e, 6'h32);
        map_key(8'h4f, 6'h14); map_key(8'h50, 6'h1c); map_key(8'h51, 6'h10);
        map_key(8'h52, 6'h19); map_key(8'h53, 6'h28); map_key(8'h54, 6'h12);
        map_key(8'h55, 6'h13); map_key(8'h56, 6'h31); map_key(8'h57, 6'h18);
        map_key(8'h58, 6'h30); map_key(8'h59, 6'h1a); map_key(8'h5a, 6'h38);
        map_key(8'h60, 6'h3f); map_key(8'h61, 6'h35); map_key(8'h62, 6'h3d);
        map_key(8'h63, 6'h3e); map_key(8'h64, 6'h25); map_key(8'h65, 6'h2d);
        map_key(8'h66, 6'h26); map_key(8'h67, 6'h15); map_key(8'h68, 6'h1d);
        map_key(8'h69, 6'h16); map_key(8'h6a, 6'h2e); map_key(8'h6b, 6'h37);
        map_key(8'h6c, 6'h2f); map_key(8'h6d, 6'h36); map_key(8'h6e, 6'h3c);
        map_key(8'h6f, 6'h1e); map_key(8'h70, 6'h35); map_key(8'h71, 6'h3d);
        map_key(8'h72, 6'h3e); map_key(8'h73, 6'h25); map_key(8'h74, 6'h2d);
        map_key(8'h75, 6'h26); map_key(8'h76, 6'h15); map_key(8'h77, 6'h1d);
        map_key(8'h78, 6'h16); map_key(8'h79, 6'h3f); map_key(8'ha3, 6'h2f);
        map_key(8'hba, 6'h1f); map_key(8'hbb, 6'h17); map_key(8'hbc, 6'h33);
        map_key(8'hbe, 6'h3c);
        foreach (queue_mirror[i])
            queue_mirror[i] = 8'h00;
        foreach (clock_field[i])
            clock_field[i] = 8'h00;
        fifo_head  = 0;
        fifo_count = 0;
        key_reg    = KEY_RESET;
        disp_flag  = 1'b0;
        opt_addr   = 16'h0000;
        opt_data   = 8'h00;
        mismatches = 0;
    endfunction

    function void map_key(logic [7:0] code, logic [5:0] matrix);
        matrix_map[code] = {1'b1, matrix};
    endfunction

    function int pending();
        return awaited_results.size();
    endfunction

    function logic [3:0] clock_digit(logic [3:0] sel);
        int v;
        if (sel > TIME_SEL_MAX)
            return 4'h0;
        v = clock_field[sel >> 1];
        return sel[0] ? 4'((v % 100) / 10) : 4'(v % 10);
    endfunction

    function void set_digit(logic [3:0] sel, logic [3:0] digit);
        int v;
        if (sel > TIME_SEL_MAX)
            return;
        v = clock_field[sel >> 1];
        if (sel[0])
            v = v % 10 + digit * 10;
        else
            v = ((v % 100) / 10) * 10 + digit;
        clock_field[sel >> 1] = 8'(v);
    endfunction

    function port_result_t predict_port_result(bus_word_t w);
        port_result_t r;
        logic [6:0]   entry;
        r = '{read_data: IDLE_BYTE, irq: 1'b0, crtc_access: CRTC_NONE,
              unknown_access: 1'b0, key_lost: 1'b0};
        disp_flag = w.display_level;
        case (w.cmd)
            CMD_WRITE: begin
                if (w.address == ADDR_CRTC_DATA)
                    r.crtc_access = CRTC_DATA;
                else if (w.address == ADDR_CRTC_INDEX)
                    r.crtc_access = CRTC_INDEX;
                else if (w.address[15:12] == IO_AREA_NIBBLE && w.address[15:8] != PORT_PAGE)
                begin
                    if (w.address[15:8] == CLOCK_PAGE) begin
                        if (opt_data[7:4] == STROBE_PREV && w.write_data[7:4] == STROBE_NEW)
                            set_digit(w.address[3:0], w.write_data[3:0]);
                    end
                    else
                        r.unknown_access = 1'b1;
                    opt_addr = w.address;
                    opt_data = w.write_data;
                end
                else
                    r.unknown_access = 1'b1;
            end
            CMD_READ: begin
                if (w.address == ADDR_STATUS)
                    r.read_data = (disp_flag ? 8'h00 : STATUS_NDISP) | STATUS_FIXED
                                  | {7'h00, key_reg[0]};
                else if (w.address == ADDR_CRTC_DATA)
                    r.crtc_access = CRTC_DATA;
                else if (w.address == ADDR_CRTC_INDEX)
                    r.crtc_access = CRTC_INDEX;
                else if (w.address == ADDR_KEY)
                    r.read_data = key_reg & KEY_MASK;
                else if (w.address == ADDR_CLOCK && opt_addr[15:8] == CLOCK_PAGE)
                    r.read_data = {4'h0, clock_digit(opt_addr[3:0])};
                else
                    r.unknown_access = 1'b1;
            end
            CMD_KEY: begin
                entry = matrix_map[w.key_code];
                if (entry[6]) begin
                    if (fifo_count >= QUEUE_DEPTH)
                        r.key_lost = 1'b1;
                    else begin
                        queue_mirror[(fifo_head + fifo_count) % QUEUE_DEPTH] =
                            {entry[5:0], 1'b0, ~w.shift_held};
                        fifo_count++;
                    end
                end
            end
            default: begin
                if (fifo_count != 0) begin
                    key_reg    = queue_mirror[fifo_head];
                    fifo_head  = (fifo_head + 1) % QUEUE_DEPTH;
                    fifo_count--;
                    r.irq      = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    function void note_word(bus_word_t w);
        awaited_results.push_back(predict_port_result(w));
    endfunction

    function void compare_field(string name, logic [7:0] expv, logic [7:0] actv);
        if (expv !== actv) begin
            $error("%s: expected %0d, actual %0d", name, expv, actv);
            mismatches++;
        end
    endfunction

    function void check_result(port_result_t got);
        port_result_t want;
        if (awaited_results.size() == 0) begin
            $error("result word with nothing outstanding");
            mismatches++;
            return;
        end
        want = awaited_results.pop_front();
        compare_field("read_data", want.read_data, got.read_data);
        compare_field("irq", want.irq, got.irq);
        compare_field("crtc_access", want.crtc_access, got.crtc_access);
        compare_field("unknown_access", want.unknown_access, got.unknown_access);
        compare_field("key_lost", want.key_lost, got.key_lost);
    endfunction
endclass

module tb_keypad_rtc_io_port_block;

    // random part length and the no-handshake limit of the watchdog
    localparam int RANDOM_WORDS = 2000;
    localparam int STALL_LIMIT  = 5000;
    // long receiver hold-off, started once enough results have come
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 600;
    // drain margin at the end
    localparam int TAIL_CYCLES  = 10;

    logic clk;
    logic rst_n;

    krio_item_if   item_ch ();
    krio_result_if res_ch ();

    keypad_rtc_io_port_block uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch)
    );

    port_result_tracker tracker;
    logic [7:0] mapped_codes [$];
    int         results_seen = 0;
    // sender burst state
    int         burst_left   = 0;
    bit         idle_on      = 1'b0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // both handshakes are sampled at the edge, before any driver update lands
    always @(posedge clk) begin
        if (rst_n) begin
            if (item_ch.valid && item_ch.ready)
                tracker.note_word(bus_word_t'{cmd: cmd_t'(item_ch.cmd),
                                              address: item_ch.address,
                                              write_data: item_ch.write_data,
                                              key_code: item_ch.key_code,
                                              shift_held: item_ch.shift_held,
                                              display_level: item_ch.display_level});
            if (res_ch.valid && res_ch.ready) begin
                tracker.check_result(port_result_t'{read_data: res_ch.read_data,
                                                    irq: res_ch.irq,
                                                    crtc_access: res_ch.crtc_access,
                                                    unknown_access: res_ch.unknown_access,
                                                    key_lost: res_ch.key_lost});
                results_seen++;
            end
        end
    end

    // offer one word; bursts of random length, with random gaps between them once idle_on is set
    task automatic send_word(input bus_word_t w);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if (idle_on)
                gap = $urandom_range(1, 20);
        end
        burst_left--;
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.cmd           <= w.cmd;
        item_ch.address       <= w.address;
        item_ch.write_data    <= w.write_data;
        item_ch.key_code      <= w.key_code;
        item_ch.shift_held    <= w.shift_held;
        item_ch.display_level <= w.display_level;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
    endtask

    // unused fields of each word carry random values
    function automatic bus_word_t noise_word();
        bus_word_t w;
        w.cmd           = cmd_t'($urandom_range(0, 3));
        w.address       = 16'($urandom);
        w.write_data    = 8'($urandom);
        w.key_code      = 8'($urandom);
        w.shift_held    = 1'($urandom);
        w.display_level = 1'($urandom);
        return w;
    endfunction

    task automatic bus_write(input logic [15:0] addr, input logic [7:0] data);
        bus_word_t w;
        w            = noise_word();
        w.cmd        = CMD_WRITE;
        w.address    = addr;
        w.write_data = data;
        send_word(w);
    endtask

    task automatic bus_read(input logic [15:0] addr);
        bus_word_t w;
        w         = noise_word();
        w.cmd     = CMD_READ;
        w.address = addr;
        send_word(w);
    endtask

    task automatic key_press(input logic [7:0] code, input logic shift);
        bus_word_t w;
        w            = noise_word();
        w.cmd        = CMD_KEY;
        w.key_code   = code;
        w.shift_held = shift;
        send_word(w);
    endtask

    task automatic frame_tick();
        bus_word_t w;
        w     = noise_word();
        w.cmd = CMD_FRAME;
        send_word(w);
    endtask

    // sender holds off until every outstanding result has come back
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending() != 0);
    endtask

    function automatic logic [3:0] pick_digit_sel();
        if ($urandom_range(0, 9) != 0)
            return 4'($urandom_range(0, 11));
        return 4'($urandom_range(12, 15));
    endfunction

    task automatic random_phase(input int word_total);
        int         sent;
        int         pick;
        bit         drained;
        logic [3:0] sel;
        logic [15:0] addr;
        logic [7:0] code;
        sent    = 0;
        drained = 1'b0;
        while (sent < word_total) begin
            // first stretch runs back to back, then the sender idles
            idle_on = (sent >= 300);
            if (!drained && sent >= word_total / 2) begin
                drain_results();
                drained = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                // mostly mapped keys so the queue fills and overflows
                if ($urandom_range(0, 4) != 0)
                    code = mapped_codes[$urandom_range(0, mapped_codes.size() - 1)];
                else
                    code = 8'($urandom);
                key_press(code, 1'($urandom));
                sent++;
            end
            else if (pick < 38) begin
                frame_tick();
                sent++;
            end
            else if (pick < 50) begin
                // digit strobe: arm with high nibble 3, then set with high nibble 1
                sel = pick_digit_sel();
                bus_write({CLOCK_PAGE, 4'($urandom), sel}, {STROBE_PREV, 4'($urandom)});
                if ($urandom_range(0, 4) == 0)
                    sel = pick_digit_sel();
                if ($urandom_range(0, 5) == 0)
                    bus_write({CLOCK_PAGE, 4'($urandom), sel}, 8'($urandom));
                else
                    bus_write({CLOCK_PAGE, 4'($urandom), sel}, {STROBE_NEW, 4'($urandom)});
                sent += 2;
                // read back the digit just latched
                if ($urandom_range(0, 2) != 0) begin
                    bus_read(ADDR_CLOCK);
                    sent++;
                end
            end
            else if (pick < 60) begin
                bus_write({CLOCK_PAGE, 8'($urandom)}, 8'($urandom));
                bus_read(ADDR_CLOCK);
                sent += 2;
            end
            else if (pick < 70) begin
                bus_read($urandom_range(0, 1) ? ADDR_STATUS : ADDR_KEY);
                sent++;
            end
            else if (pick < 78) begin
                addr = $urandom_range(0, 1) ? ADDR_CRTC_DATA : ADDR_CRTC_INDEX;
                if ($urandom_range(0, 1))
                    bus_write(addr, 8'($urandom));
                else
                    bus_read(addr);
                sent++;
            end
            else if (pick < 90) begin
                // anywhere in the i/o area, option pages and port page alike
                addr = {IO_AREA_NIBBLE, 12'($urandom)};
                if ($urandom_range(0, 1))
                    bus_write(addr, 8'($urandom));
                else
                    bus_read(addr);
                sent++;
            end
            else begin
                send_word(noise_word());
                sent++;
            end
        end
    endtask

    // receiver: changing ready pattern plus one long hold-off
    initial begin : result_sink
        int          mode;
        int          mode_left;
        logic [15:0] pattern;
        bit          hold_done;
        res_ch.ready <= 1'b0;
        mode_left = 0;
        mode      = 0;
        pattern   = 16'hffff;
        hold_done = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && !hold_done && results_seen >= HOLD_AFTER) begin
                // block fills up while the sender keeps offering words
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(8, 64);
                    pattern   = 16'($urandom);
                end
                mode_left--;
                pattern = {pattern[14:0], pattern[15]};
                case (mode)
                    0: res_ch.ready <= 1'b1;
                    1: res_ch.ready <= 1'($urandom);
                    2: res_ch.ready <= pattern[0];
                    default: res_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ends the run when no word moves on either channel for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        tracker = new();
        foreach (tracker.matrix_map[i])
            if (tracker.matrix_map[i][6])
                mapped_codes.push_back(8'(i));
        item_ch.valid         <= 1'b0;
        item_ch.cmd           <= CMD_WRITE;
        item_ch.address       <= 16'h0000;
        item_ch.write_data    <= 8'h00;
        item_ch.key_code      <= 8'h00;
        item_ch.shift_held    <= 1'b0;
        item_ch.display_level <= 1'b0;
        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // status right after reset, key register still all ones
        bus_read(ADDR_STATUS);
        // frame tick with an empty queue
        frame_tick();
        // crtc ports only signal outward
        bus_write(ADDR_CRTC_DATA, 8'hff);
        // undecoded: bottom of the map and the port page itself
        bus_write(16'h0000, 8'h00);
        bus_write({PORT_PAGE, 8'h00}, 8'h5a);
        // tens strobe on seconds, 15 tens wraps the tens digit read
        bus_write({CLOCK_PAGE, 8'h01}, 8'h35);
        bus_write({CLOCK_PAGE, 8'h01}, 8'h1f);
        bus_read(ADDR_CLOCK);
        // units strobe on seconds
        bus_write({CLOCK_PAGE, 8'h00}, 8'h30);
        bus_write({CLOCK_PAGE, 8'h00}, 8'h19);
        bus_read(ADDR_CLOCK);
        // selector past the year digits sets nothing and reads zero
        bus_write({CLOCK_PAGE, 8'h0c}, 8'h30);
        bus_write({CLOCK_PAGE, 8'h0c}, 8'h15);
        bus_read(ADDR_CLOCK);
        // option page outside the clock group, then clock read refused
        bus_write(16'h6105, 8'h00);
        bus_read(ADDR_CLOCK);
        // fill the queue, one more mapped press is dropped
        key_press(8'h0d, 1'b0);
        key_press(8'h20, 1'b1);
        key_press(8'h30, 1'b0);
        key_press(8'h41, 1'b1);
        key_press(8'h5a, 1'b0);
        key_press(8'h60, 1'b1);
        key_press(8'h79, 1'b0);
        key_press(8'ha3, 1'b1);
        key_press(8'hbe, 1'b0);
        // unmapped press is ignored, no flag
        key_press(8'hff, 1'b1);
        frame_tick();
        bus_read(ADDR_KEY);

        random_phase(RANDOM_WORDS);

        // the drain waits on the edge, so the last accepted word is noted before counting
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
